// ----- hw/rtl/fcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants of the four-channel sound generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam int unsigned NUM_REGS = 21;
  localparam int unsigned NUM_OFFS = 23;

  localparam logic [4:0] SL_NR10 = 5'd0;
  localparam logic [4:0] SL_NR11 = 5'd1;
  localparam logic [4:0] SL_NR12 = 5'd2;
  localparam logic [4:0] SL_NR13 = 5'd3;
  localparam logic [4:0] SL_NR14 = 5'd4;
  localparam logic [4:0] SL_NR21 = 5'd5;
  localparam logic [4:0] SL_NR22 = 5'd6;
  localparam logic [4:0] SL_NR23 = 5'd7;
  localparam logic [4:0] SL_NR24 = 5'd8;
  localparam logic [4:0] SL_NR30 = 5'd9;
  localparam logic [4:0] SL_NR31 = 5'd10;
  localparam logic [4:0] SL_NR32 = 5'd11;
  localparam logic [4:0] SL_NR33 = 5'd12;
  localparam logic [4:0] SL_NR34 = 5'd13;
  localparam logic [4:0] SL_NR41 = 5'd14;
  localparam logic [4:0] SL_NR42 = 5'd15;
  localparam logic [4:0] SL_NR43 = 5'd16;
  localparam logic [4:0] SL_NR44 = 5'd17;
  localparam logic [4:0] SL_NR50 = 5'd18;
  localparam logic [4:0] SL_NR52 = 5'd20;
  localparam logic [4:0] SL_NONE = 5'd31;

  localparam logic [7:0] A_NR11 = 8'h11;
  localparam logic [7:0] A_NR14 = 8'h14;
  localparam logic [7:0] A_NR21 = 8'h16;
  localparam logic [7:0] A_NR24 = 8'h19;
  localparam logic [7:0] A_NR31 = 8'h1B;
  localparam logic [7:0] A_NR34 = 8'h1E;
  localparam logic [7:0] A_NR41 = 8'h20;
  localparam logic [7:0] A_NR43 = 8'h22;
  localparam logic [7:0] A_NR44 = 8'h23;
  localparam logic [7:0] A_NR52 = 8'h26;

  localparam logic [4:0] REG_SLOT [NUM_OFFS] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, SL_NONE, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd11, 5'd12, 5'd13, SL_NONE, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20
  };

  localparam logic [7:0] REG_MASK [NUM_OFFS] = '{
    8'h80, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'h7F,
    8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF, 8'hC0, 8'h00, 8'h00, 8'hBF, 8'h00, 8'h00,
    8'h70
  };

  localparam logic [7:0] DUTY_BITS [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};
  localparam logic [6:0] NOISE_DIV [8] = '{7'd8, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80,
                                           7'd96, 7'd112};
  localparam logic [2:0] WAVE_SHIFT [4] = '{3'd4, 3'd0, 3'd1, 3'd2};

  localparam logic [14:0] LFSR_SEED = 15'h7FFF;
  localparam logic [11:0] FREQ_BASE = 12'd2048;

  // Reciprocal of 400 scaled by 2^26, exact for the products that occur here.
  localparam logic [17:0] RECIP_400 = 18'd167773;
  localparam int unsigned RECIP_SHIFT = 26;

  localparam int unsigned ACC_W = 23;
  localparam int unsigned PER_W = 22;

  typedef struct packed {
    logic       power;
    logic [6:0] user_volume;
    logic [5:0] level;
    logic [2:0] vol_left;
    logic [2:0] vol_right;
  } mix_req_t;

endpackage

// ----- hw/rtl/four_channel_sound_generator.sv -----
// ----------------------------------------------------------------------------
// four_channel_sound_generator
// Four-channel sound unit with bus access, tick sequencing and PWM mixing.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// in       slave      in_valid_i/in_ready_o, cmd_i, addr_i, write_data_i,
//                     cycle_count_i
// out      master     out_valid_o/out_ready_i, read_data_o, sample_o
// cfg      slave      cfg_valid_i/cfg_ready_o, user_volume_i
//
// A read or write runs the execute, prepare, mix, mix-wait and output states.
// A powered tick adds the frame state for each frame event and, per channel, a
// load and, while running, timer steps in the shared compare and subtract unit
// until no wrap is left, more while a timer left above a newly shortened period
// catches up. Reset clears the control and channel state at once, but not the
// wave memory or captured request. A stalled result holds the output register;
// the next transfer is taken as soon as the sequencer returns to idle.
// ----------------------------------------------------------------------------
module four_channel_sound_generator #(
  parameter int unsigned PWM_MAX      = 1023,
  parameter int unsigned FRAME_PERIOD = 8192,
  parameter int unsigned MAX_TICK     = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  cycle_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [9:0]  sample_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  user_volume_i
);

  localparam int unsigned FCW = $clog2(FRAME_PERIOD + MAX_TICK + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_FRAME = 4'd2;
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_STEP  = 4'd4;
  localparam logic [3:0] ST_PREP  = 4'd5;
  localparam logic [3:0] ST_MIX   = 4'd6;
  localparam logic [3:0] ST_MWAIT = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]  state_q;
  logic [1:0]  cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [7:0]  cyc_q;
  logic [6:0]  uv_q;
  logic [7:0]  rdata_q;
  logic        rd_wave_q;
  logic        out_valid_q;
  logic [7:0]  out_rdata_q;
  logic [9:0]  out_sample_q;
  logic [9:0]  mix_sample_q;

  logic [7:0]  regs_q [fcsg_pkg::NUM_REGS];
  logic [7:0]  wave_mem [16];
  logic [15:0] wave_vld_q;
  logic [7:0]  wave_dat_q;
  logic        wave_hit_q;
  logic [3:0]  wave_raddr;
  logic [7:0]  wave_byte;

  logic        power_q;
  logic [FCW-1:0] frame_cnt_q;
  logic [2:0]  frame_step_q;
  logic [3:0]  chan_en_q;
  logic [8:0]  len_q [4];
  logic [1:0]  duty_sel_q [2];
  logic [2:0]  duty_pos_q [2];
  logic [13:0] sq_per_q [2];
  logic [13:0] sq_tmr_q [2];
  logic [10:0] sweep_freq_q;
  logic [10:0] shadow_q;
  logic [3:0]  sweep_cnt_q;
  logic        sweep_on_q;
  logic [3:0]  env_vol_q [3];
  logic [2:0]  env_cnt_q [3];
  logic [12:0] wave_per_q;
  logic [12:0] wave_tmr_q;
  logic [4:0]  wave_pos_q;
  logic [21:0] noise_per_q;
  logic [21:0] noise_tmr_q;
  logic [14:0] noise_sr_q;

  logic [1:0]                 ch_q;
  logic [fcsg_pkg::ACC_W-1:0] acc_q;
  logic [fcsg_pkg::PER_W-1:0] cur_per;
  logic [fcsg_pkg::ACC_W-1:0] cur_tmr;
  logic                       cur_run;
  logic                       wrap;
  logic [fcsg_pkg::ACC_W-1:0] rest;

  logic               mix_start;
  fcsg_pkg::mix_req_t mix_req;
  logic               mix_done;
  logic [9:0]         mix_sample;

  logic [7:0]  cyc_sat;
  logic [4:0]  slot;
  logic [7:0]  reg_mask;
  logic        in_range;
  logic [7:0]  lvl_wave;
  logic [3:0]  nib;
  logic [5:0]  level;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rdata_q;
  assign sample_o    = out_sample_q;

  assign cyc_sat = (32'(cycle_count_i) > MAX_TICK) ? 8'(MAX_TICK) : cycle_count_i;

  always_comb begin
    in_range = (addr_q[15:8] == 8'hFF) && (addr_q[7:0] >= 8'h10) &&
               (addr_q[7:0] <= fcsg_pkg::A_NR52);
    slot     = fcsg_pkg::SL_NONE;
    reg_mask = 8'hFF;
    if (in_range) begin
      slot     = fcsg_pkg::REG_SLOT[5'(addr_q[7:0] - 8'h10)];
      reg_mask = fcsg_pkg::REG_MASK[5'(addr_q[7:0] - 8'h10)];
    end
  end

  always_comb begin
    case (ch_q)
      2'd0: begin
        cur_per = fcsg_pkg::PER_W'(sq_per_q[0]);
        cur_tmr = fcsg_pkg::ACC_W'(sq_tmr_q[0]);
      end
      2'd1: begin
        cur_per = fcsg_pkg::PER_W'(sq_per_q[1]);
        cur_tmr = fcsg_pkg::ACC_W'(sq_tmr_q[1]);
      end
      2'd2: begin
        cur_per = fcsg_pkg::PER_W'(wave_per_q);
        cur_tmr = fcsg_pkg::ACC_W'(wave_tmr_q);
      end
      default: begin
        cur_per = noise_per_q;
        cur_tmr = fcsg_pkg::ACC_W'(noise_tmr_q);
      end
    endcase
    cur_run = chan_en_q[ch_q] && (cur_per != '0);
  end

  fcsg_step u_step (
    .acc_i    (acc_q),
    .period_i (cur_per),
    .wrap_o   (wrap),
    .rest_o   (rest)
  );

  assign wave_raddr = (state_q == ST_EXEC) ? addr_q[3:0] : wave_pos_q[4:1];
  assign wave_byte  = wave_hit_q ? wave_dat_q : 8'h00;

  always_ff @(posedge clk_i) begin
    wave_dat_q <= wave_mem[wave_raddr];
    if ((state_q == ST_EXEC) && (cmd_q == fcsg_pkg::CMD_WRITE) &&
        (addr_q[15:4] == 12'hFF3)) begin
      wave_mem[addr_q[3:0]] <= wdata_q;
    end
  end

  always_comb begin
    nib      = wave_pos_q[0] ? wave_byte[3:0] : wave_byte[7:4];
    lvl_wave = 8'(nib >> fcsg_pkg::WAVE_SHIFT[regs_q[fcsg_pkg::SL_NR32][6:5]]);
    level    = '0;
    if (chan_en_q[0] && fcsg_pkg::DUTY_BITS[duty_sel_q[0]][duty_pos_q[0]]) begin
      level = level + 6'(env_vol_q[0]);
    end
    if (chan_en_q[1] && fcsg_pkg::DUTY_BITS[duty_sel_q[1]][duty_pos_q[1]]) begin
      level = level + 6'(env_vol_q[1]);
    end
    if (chan_en_q[2] && regs_q[fcsg_pkg::SL_NR30][7]) begin
      level = level + 6'(lvl_wave);
    end
    if (chan_en_q[3] && !noise_sr_q[0]) begin
      level = level + 6'(env_vol_q[2]);
    end
  end

  assign mix_start         = (state_q == ST_MIX);
  assign mix_req.power     = power_q;
  assign mix_req.user_volume = uv_q;
  assign mix_req.level     = level;
  assign mix_req.vol_left  = regs_q[fcsg_pkg::SL_NR50][6:4];
  assign mix_req.vol_right = regs_q[fcsg_pkg::SL_NR50][2:0];

  fcsg_mix #(
    .PWM_MAX (PWM_MAX)
  ) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mix_start),
    .req_i    (mix_req),
    .done_o   (mix_done),
    .sample_o (mix_sample)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      wdata_q <= write_data_i;
      cyc_q   <= cyc_sat;
    end
    if (mix_done) begin
      mix_sample_q <= mix_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [7:0]  v;
    logic [10:0] f;
    logic [2:0]  per;
    logic [2:0]  sh;
    logic [11:0] delta;
    logic [11:0] nf;
    logic [3:0]  scnt;
    logic [2:0]  ecnt;
    logic [7:0]  er;
    logic        b;
    logic [14:0] sr;
    logic        do_len;
    logic        do_sweep;
    logic        do_env;
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      uv_q         <= 7'd100;
      rdata_q      <= '0;
      rd_wave_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_rdata_q  <= '0;
      out_sample_q <= '0;
      wave_vld_q   <= '0;
      wave_hit_q   <= 1'b0;
      power_q      <= 1'b0;
      frame_cnt_q  <= '0;
      frame_step_q <= '0;
      chan_en_q    <= '0;
      for (int i = 0; i < fcsg_pkg::NUM_REGS; i++) regs_q[i] <= '0;
      for (int i = 0; i < 4; i++) len_q[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        duty_sel_q[i] <= '0;
        duty_pos_q[i] <= '0;
        sq_per_q[i]   <= '0;
        sq_tmr_q[i]   <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        env_vol_q[i] <= '0;
        env_cnt_q[i] <= '0;
      end
      sweep_freq_q <= '0;
      shadow_q     <= '0;
      sweep_cnt_q  <= '0;
      sweep_on_q   <= 1'b0;
      wave_per_q   <= '0;
      wave_tmr_q   <= '0;
      wave_pos_q   <= '0;
      noise_per_q  <= '0;
      noise_tmr_q  <= '0;
      noise_sr_q   <= '0;
      ch_q         <= '0;
      acc_q        <= '0;
    end else begin
      v = wdata_q;
      if (cfg_valid_i && cfg_ready_o) begin
        uv_q <= user_volume_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      wave_hit_q <= wave_vld_q[wave_raddr];
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rdata_q   <= '0;
          rd_wave_q <= 1'b0;
          state_q   <= ST_PREP;
          case (cmd_q)
            fcsg_pkg::CMD_READ: begin
              if (addr_q[15:4] == 12'hFF3) begin
                rd_wave_q <= 1'b1;
              end else if (!in_range || (slot == fcsg_pkg::SL_NONE)) begin
                rdata_q <= 8'hFF;
              end else if (addr_q[7:0] == fcsg_pkg::A_NR52) begin
                rdata_q <= {power_q, 7'h70};
              end else begin
                rdata_q <= regs_q[slot] | reg_mask;
              end
            end
            fcsg_pkg::CMD_WRITE: begin
              if (addr_q[15:4] == 12'hFF3) begin
                wave_vld_q[addr_q[3:0]] <= 1'b1;
              end else if ((power_q || addr_q == 16'hFF26) && in_range &&
                           (slot != fcsg_pkg::SL_NONE)) begin
                if (addr_q[7:0] != fcsg_pkg::A_NR52) begin
                  regs_q[slot] <= v;
                end
                case (addr_q[7:0])
                  fcsg_pkg::A_NR11: begin
                    duty_sel_q[0] <= v[7:6];
                    len_q[0]      <= 9'(7'd64 - 7'(v[5:0]));
                  end
                  fcsg_pkg::A_NR14: begin
                    f = {v[2:0], regs_q[fcsg_pkg::SL_NR13]};
                    sweep_freq_q <= f;
                    sq_per_q[0]  <= {12'(fcsg_pkg::FREQ_BASE - 12'(f)), 2'b00};
                    if (v[7]) begin
                      chan_en_q[0] <= 1'b1;
                      if (len_q[0] == '0) len_q[0] <= 9'd64;
                      env_vol_q[0] <= regs_q[fcsg_pkg::SL_NR12][7:4];
                      env_cnt_q[0] <= regs_q[fcsg_pkg::SL_NR12][2:0];
                      shadow_q     <= f;
                      sweep_cnt_q  <= {1'b0, regs_q[fcsg_pkg::SL_NR10][6:4]};
                      sweep_on_q   <= (regs_q[fcsg_pkg::SL_NR10][6:4] != 3'd0) ||
                                      (regs_q[fcsg_pkg::SL_NR10][2:0] != 3'd0);
                    end
                  end
                  fcsg_pkg::A_NR21: begin
                    duty_sel_q[1] <= v[7:6];
                    len_q[1]      <= 9'(7'd64 - 7'(v[5:0]));
                  end
                  fcsg_pkg::A_NR24: begin
                    f = {v[2:0], regs_q[fcsg_pkg::SL_NR23]};
                    sq_per_q[1] <= {12'(fcsg_pkg::FREQ_BASE - 12'(f)), 2'b00};
                    if (v[7]) begin
                      chan_en_q[1] <= 1'b1;
                      if (len_q[1] == '0) len_q[1] <= 9'd64;
                      env_vol_q[1] <= regs_q[fcsg_pkg::SL_NR22][7:4];
                      env_cnt_q[1] <= regs_q[fcsg_pkg::SL_NR22][2:0];
                    end
                  end
                  fcsg_pkg::A_NR31: begin
                    len_q[2] <= 9'(9'd256 - 9'(v));
                  end
                  fcsg_pkg::A_NR34: begin
                    f = {v[2:0], regs_q[fcsg_pkg::SL_NR33]};
                    wave_per_q <= {12'(fcsg_pkg::FREQ_BASE - 12'(f)), 1'b0};
                    if (v[7]) begin
                      chan_en_q[2] <= regs_q[fcsg_pkg::SL_NR30][7];
                      if (len_q[2] == '0) len_q[2] <= 9'd256;
                      wave_pos_q <= '0;
                    end
                  end
                  fcsg_pkg::A_NR41: begin
                    len_q[3] <= 9'(7'd64 - 7'(v[5:0]));
                  end
                  fcsg_pkg::A_NR43: begin
                    noise_per_q <= 22'(fcsg_pkg::NOISE_DIV[v[2:0]]) << v[7:4];
                  end
                  fcsg_pkg::A_NR44: begin
                    if (v[7]) begin
                      chan_en_q[3] <= 1'b1;
                      if (len_q[3] == '0) len_q[3] <= 9'd64;
                      env_vol_q[2] <= regs_q[fcsg_pkg::SL_NR42][7:4];
                      env_cnt_q[2] <= regs_q[fcsg_pkg::SL_NR42][2:0];
                      noise_sr_q   <= fcsg_pkg::LFSR_SEED;
                    end
                  end
                  fcsg_pkg::A_NR52: begin
                    power_q                      <= v[7];
                    regs_q[fcsg_pkg::SL_NR52]    <= {v[7], 7'd0};
                    if (!v[7]) chan_en_q <= '0;
                  end
                  default: begin
                  end
                endcase
              end
            end
            fcsg_pkg::CMD_TICK: begin
              if (power_q) begin
                frame_cnt_q <= frame_cnt_q + FCW'(cyc_q);
                state_q     <= ST_FRAME;
              end
            end
            default: begin
            end
          endcase
        end
        ST_FRAME: begin
          if (frame_cnt_q >= FCW'(FRAME_PERIOD)) begin
            frame_cnt_q  <= frame_cnt_q - FCW'(FRAME_PERIOD);
            frame_step_q <= frame_step_q + 3'd1;
            do_len   = (frame_step_q[0] == 1'b0);
            do_sweep = (frame_step_q == 3'd2) || (frame_step_q == 3'd6);
            do_env   = (frame_step_q == 3'd7);
            if (do_len) begin
              if (regs_q[fcsg_pkg::SL_NR14][6] && len_q[0] != '0) begin
                len_q[0] <= len_q[0] - 9'd1;
                if (len_q[0] == 9'd1) chan_en_q[0] <= 1'b0;
              end
              if (regs_q[fcsg_pkg::SL_NR24][6] && len_q[1] != '0) begin
                len_q[1] <= len_q[1] - 9'd1;
                if (len_q[1] == 9'd1) chan_en_q[1] <= 1'b0;
              end
              if (regs_q[fcsg_pkg::SL_NR34][6] && len_q[2] != '0) begin
                len_q[2] <= len_q[2] - 9'd1;
                if (len_q[2] == 9'd1) chan_en_q[2] <= 1'b0;
              end
              if (regs_q[fcsg_pkg::SL_NR44][6] && len_q[3] != '0) begin
                len_q[3] <= len_q[3] - 9'd1;
                if (len_q[3] == 9'd1) chan_en_q[3] <= 1'b0;
              end
            end
            if (do_sweep && sweep_on_q) begin
              per   = regs_q[fcsg_pkg::SL_NR10][6:4];
              sh    = regs_q[fcsg_pkg::SL_NR10][2:0];
              scnt  = (sweep_cnt_q != '0) ? sweep_cnt_q - 4'd1 : sweep_cnt_q;
              delta = 12'(shadow_q >> sh);
              nf    = regs_q[fcsg_pkg::SL_NR10][3] ? 12'(shadow_q) - delta
                                                   : 12'(shadow_q) + delta;
              if (scnt != '0) begin
                sweep_cnt_q <= scnt;
              end else begin
                sweep_cnt_q <= (per != '0) ? {1'b0, per} : 4'd8;
                if (per != '0) begin
                  if (nf[11]) begin
                    chan_en_q[0] <= 1'b0;
                  end else if (sh != '0) begin
                    shadow_q     <= nf[10:0];
                    sweep_freq_q <= nf[10:0];
                    sq_per_q[0]  <= {12'(fcsg_pkg::FREQ_BASE - nf), 2'b00};
                  end
                end
              end
            end
            if (do_env) begin
              for (int e = 0; e < 3; e++) begin
                er = (e == 0) ? regs_q[fcsg_pkg::SL_NR12] :
                     (e == 1) ? regs_q[fcsg_pkg::SL_NR22] : regs_q[fcsg_pkg::SL_NR42];
                if (er[2:0] != '0) begin
                  ecnt = (env_cnt_q[e] != '0) ? env_cnt_q[e] - 3'd1 : env_cnt_q[e];
                  if (ecnt == '0) begin
                    env_cnt_q[e] <= er[2:0];
                    if (er[3] && env_vol_q[e] != 4'd15) begin
                      env_vol_q[e] <= env_vol_q[e] + 4'd1;
                    end else if (!er[3] && env_vol_q[e] != 4'd0) begin
                      env_vol_q[e] <= env_vol_q[e] - 4'd1;
                    end
                  end else begin
                    env_cnt_q[e] <= ecnt;
                  end
                end
              end
            end
          end else begin
            ch_q    <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (cur_run) begin
            acc_q   <= cur_tmr + fcsg_pkg::ACC_W'(cyc_q);
            state_q <= ST_STEP;
          end else if (ch_q == 2'd3) begin
            state_q <= ST_PREP;
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        ST_STEP: begin
          if (wrap) begin
            acc_q <= rest;
            case (ch_q)
              2'd0: duty_pos_q[0] <= duty_pos_q[0] + 3'd1;
              2'd1: duty_pos_q[1] <= duty_pos_q[1] + 3'd1;
              2'd2: wave_pos_q    <= wave_pos_q + 5'd1;
              default: begin
                b  = noise_sr_q[0] ^ noise_sr_q[1];
                sr = {b, noise_sr_q[14:1]};
                if (regs_q[fcsg_pkg::SL_NR43][3]) sr[6] = b;
                noise_sr_q <= sr;
              end
            endcase
          end else begin
            case (ch_q)
              2'd0: sq_tmr_q[0] <= acc_q[13:0];
              2'd1: sq_tmr_q[1] <= acc_q[13:0];
              2'd2: wave_tmr_q  <= acc_q[12:0];
              default: noise_tmr_q <= acc_q[21:0];
            endcase
            if (ch_q == 2'd3) begin
              state_q <= ST_PREP;
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_PREP: begin
          if (rd_wave_q) begin
            rdata_q <= wave_byte;
          end
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          state_q <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mix_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_rdata_q  <= rdata_q;
            out_sample_q <= mix_sample_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/fcsg_step.sv -----
// ----------------------------------------------------------------------------
// fcsg_step
// Shared compare and subtract unit that advances all channel timers.
// ----------------------------------------------------------------------------
module fcsg_step (
  input  logic [fcsg_pkg::ACC_W-1:0] acc_i,
  input  logic [fcsg_pkg::PER_W-1:0] period_i,
  output logic                       wrap_o,
  output logic [fcsg_pkg::ACC_W-1:0] rest_o
);

  logic [fcsg_pkg::ACC_W-1:0] per_ext;

  assign per_ext = fcsg_pkg::ACC_W'(period_i);
  assign wrap_o  = (acc_i >= per_ext);
  assign rest_o  = acc_i - per_ext;

endmodule

// ----- hw/rtl/fcsg_mix.sv -----
// ----------------------------------------------------------------------------
// fcsg_mix
// Four-stage mixer: level scaling, master and user volume, clamping.
// ----------------------------------------------------------------------------
module fcsg_mix #(
  parameter int unsigned PWM_MAX = 1023
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fcsg_pkg::mix_req_t req_i,
  output logic               done_o,
  output logic [9:0]         sample_o
);

  localparam int unsigned PW  = $clog2(PWM_MAX + 1);
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned MID = PWM_MAX / 2;

  logic [3:0]        vld_q;
  logic              mute1_q, mute2_q, mute3_q;
  logic [6:0]        uv1_q;
  logic signed [9:0] half_q;
  logic              neg2_q, neg3_q;
  logic [16:0]       x_q;
  logic [34:0]       prod_q;
  logic [9:0]        sample_q;

  logic [7:0]         lvl3;
  logic [5:0]         comp;
  logic [3:0]         vsum;
  logic [3:0]         vmul;
  logic [9:0]         cv;
  logic signed [11:0] t;
  logic [8:0]         mag;
  logic [15:0]        mu;
  logic [8:0]         q;
  logic signed [SW-1:0] outv;
  logic [PW-1:0]      clamped;

  always_comb begin
    lvl3 = 8'({2'b00, req_i.level} + {1'b0, req_i.level, 1'b0});
    comp = lvl3[7:2];
    vsum = 4'({1'b0, req_i.vol_left} + {1'b0, req_i.vol_right});
    vmul = 4'({1'b0, vsum[3:1]} + 4'd1);
    cv   = 10'(comp * vmul);
    t    = 12'(($signed({2'b00, cv}) - 12'sd144) * 12'sd3);
  end

  always_comb begin
    mag = half_q[9] ? 9'(-half_q) : half_q[8:0];
    mu  = 16'(mag * uv1_q);
  end

  always_comb begin
    q    = prod_q[fcsg_pkg::RECIP_SHIFT +: 9];
    outv = neg3_q ? SW'(MID) - SW'(q) : SW'(MID) + SW'(q);
    if (mute3_q) begin
      clamped = PW'(MID);
    end else if (outv < 0) begin
      clamped = '0;
    end else if (outv > SW'(PWM_MAX)) begin
      clamped = PW'(PWM_MAX);
    end else begin
      clamped = PW'(outv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mute1_q  <= !req_i.power || (req_i.user_volume == 7'd0);
    uv1_q    <= req_i.user_volume;
    half_q   <= 10'(t >>> 1);
    mute2_q  <= mute1_q;
    neg2_q   <= half_q[9];
    x_q      <= 17'({1'b0, mu} + {mu, 1'b0});
    mute3_q  <= mute2_q;
    neg3_q   <= neg2_q;
    prod_q   <= 35'(x_q * fcsg_pkg::RECIP_400);
    sample_q <= 10'(clamped);
  end

  assign done_o   = vld_q[3];
  assign sample_o = sample_q;

endmodule

// ----- hw/rtl/fcsg_chk.sv -----
// ----------------------------------------------------------------------------
// fcsg_chk
// Port-level checks of the four-channel sound generator, bound to the top.
// ----------------------------------------------------------------------------
module fcsg_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic [9:0] sample_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(read_data_o) && $stable(sample_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind four_channel_sound_generator fcsg_chk u_fcsg_chk (.*);
